// File: hw/rtl/gated_object_track_vote_core_defines.svh
// assertion macros for the track vote core
`ifndef GATED_OBJECT_TRACK_VOTE_CORE_DEFINES_SVH
`define GATED_OBJECT_TRACK_VOTE_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define GOTV_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next clock cycle
`define GOTV_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/gotv_pkg.sv
// shared types and constants of the track vote core
`timescale 1ns / 1ps
package gotv_pkg;
    localparam int MaxTracks = 16;
    localparam int NumColors = 5;
    localparam int NumShapes = 3;
    localparam int TrkW = $clog2(MaxTracks + 1);
    localparam logic [7:0] CntMax = 8'd255;

    localparam logic [1:0] REG_CALIBRATED = 2'd0;
    localparam logic [1:0] REG_POS_TOL    = 2'd1;
    localparam logic [1:0] REG_AREA_TOL   = 2'd2;
    localparam logic [1:0] REG_MIN_LEN    = 2'd3;

    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [7:0]  z;
        logic [15:0] area;
        logic [2:0]  color;
        logic [1:0]  shape;
    } t_det;

    // payload moving along the cell row
    typedef struct packed {
        logic        valid;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [7:0]  z;
        logic [15:0] area;
        logic [7:0]  len;
        logic [NumColors*8-1:0] cvotes;
        logic [NumShapes*8-1:0] svotes;
    } t_track;

    // control travelling with the detection token
    typedef struct packed {
        logic  active;
        logic  done;
        t_det  det;
    } t_tok;

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        return (c == CntMax) ? c : c + 8'd1;
    endfunction

    // strict window ref-tol < v < ref+tol without wrap
    function automatic logic in_win(input logic [15:0] v, input logic [15:0] r,
                                    input logic [15:0] t);
        logic [16:0] lo;
        logic [16:0] hi;
        lo = {1'b0, r} - {1'b0, t};
        hi = {1'b0, r} + {1'b0, t};
        return ({1'b0, v} < hi) && ((t > r) || ({1'b0, v} > lo));
    endfunction
endpackage

// File: hw/rtl/gotv_cell.sv
// one track slot: holds a track and checks the passing detection token
`timescale 1ns / 1ps
module gotv_cell
    import gotv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_shift,
    input  t_tok        i_tok,
    input  t_track      i_trk,
    input  logic [9:0]  i_pos_tol,
    input  logic [15:0] i_area_tol,
    input  logic        i_first_pass,
    output t_tok        o_tok,
    output t_track      o_trk
);
    t_track r_trk;
    t_tok   r_tok;
    t_track n_trk;
    t_tok   n_tok;
    logic   w_hit;

    assign w_hit = r_trk.valid &&
        in_win({6'd0, i_tok.det.x}, {6'd0, r_trk.x}, {6'd0, i_pos_tol}) &&
        in_win({6'd0, i_tok.det.y}, {6'd0, r_trk.y}, {6'd0, i_pos_tol}) &&
        in_win(i_tok.det.area, r_trk.area, i_area_tol);

    always_comb begin
        n_trk = r_trk;
        n_tok = i_tok;
        // first pass: match; second pass: open in free slot
        if (i_tok.active && !i_tok.done &&
            ((i_first_pass && w_hit) || (!i_first_pass && !r_trk.valid))) begin
            if (!r_trk.valid) begin
                n_trk.len = '0;
                n_trk.cvotes = '0;
                n_trk.svotes = '0;
            end
            n_trk.valid = 1'b1;
            n_trk.x = i_tok.det.x;
            n_trk.y = i_tok.det.y;
            n_trk.z = i_tok.det.z;
            n_trk.area = i_tok.det.area;
            n_trk.len = sat_inc(n_trk.len);
            for (int c = 0; c < NumColors; c++) begin
                if (i_tok.det.color == 3'(c))
                    n_trk.cvotes[c*8 +: 8] = sat_inc(n_trk.cvotes[c*8 +: 8]);
            end
            for (int s = 0; s < NumShapes; s++) begin
                if (i_tok.det.shape == 2'(s))
                    n_trk.svotes[s*8 +: 8] = sat_inc(n_trk.svotes[s*8 +: 8]);
            end
            n_tok.done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_trk <= '0;
            r_tok <= '0;
        end else if (i_shift) begin
            r_trk <= i_trk;
        end else begin
            r_trk <= n_trk;
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;
    assign o_trk = r_trk;
endmodule

// File: hw/rtl/gotv_vote.sv
// plurality vote of color and shape for the track at the row head; a tie goes to the lower code
`timescale 1ns / 1ps
module gotv_vote
    import gotv_pkg::*;
(
    input  t_track     i_trk,
    output logic [2:0] o_color,
    output logic [1:0] o_shape
);
    always_comb begin
        o_color = '0;
        for (int c = 1; c < NumColors; c++) begin
            if (i_trk.cvotes[c*8 +: 8] > i_trk.cvotes[o_color*8 +: 8])
                o_color = 3'(c);
        end
        o_shape = '0;
        for (int s = 1; s < NumShapes; s++) begin
            if (i_trk.svotes[s*8 +: 8] > i_trk.svotes[o_shape*8 +: 8])
                o_shape = 2'(s);
        end
    end
endmodule

// File: hw/rtl/gated_object_track_vote_core.sv
// top level: track table as a row of slot cells with a token pass and flush shift
//
// channel  | handshake        | payload
// config   | i_cfg_we         | i_cfg_index, i_cfg_data
// input    | i_start / o_busy | i_command, i_pos_*, i_depth_z, i_fill_area, codes
// result   | o_valid          | o_kind, o_obj_*, o_overflow, o_last
//
// a detection token walks the row once to match and ends there when a track matches;
// else a second walk looks for a free slot, and the detection is dropped if none is free
// a flush shifts all 16 slots past the head, one report candidate a cycle,
// then the end marker; the table clears as it shifts out
// an ignored detection leaves the table as it is; reset empties the table at once
// results go out for one cycle each, the receiver cannot stall
`timescale 1ns / 1ps
`include "gated_object_track_vote_core_defines.svh"
module gated_object_track_vote_core
    import gotv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_command,
    input  logic [9:0]  i_pos_x,
    input  logic [9:0]  i_pos_y,
    input  logic [7:0]  i_depth_z,
    input  logic [15:0] i_fill_area,
    input  logic [2:0]  i_color_code,
    input  logic [1:0]  i_shape_code,
    output logic        o_valid,
    output logic        o_kind,
    output logic [9:0]  o_obj_x,
    output logic [9:0]  o_obj_y,
    output logic [7:0]  o_obj_z,
    output logic [2:0]  o_obj_color,
    output logic [1:0]  o_obj_shape,
    output logic        o_overflow,
    output logic        o_last
);
    typedef enum logic [1:0] {ST_IDLE, ST_PASS1, ST_PASS2, ST_FLUSH} t_state;

    t_state      r_state;
    logic [TrkW-1:0] r_cnt;
    logic        r_cal;
    logic [9:0]  r_pos_tol;
    logic [15:0] r_area_tol;
    logic [7:0]  r_min_len;
    logic        r_dropped;
    t_det        r_det;

    t_tok   w_tok [MaxTracks+1];
    t_track w_trk [MaxTracks];
    logic   w_shift;
    logic   w_inject;
    logic   w_accept;
    logic [2:0] w_color;
    logic [1:0] w_shape;
    t_track w_empty;

    assign w_accept = i_start && !o_busy;
    assign o_busy = (r_state != ST_IDLE);
    assign w_shift = (r_state == ST_FLUSH) && (r_cnt < TrkW'(MaxTracks));
    assign w_inject = ((r_state == ST_PASS1) || (r_state == ST_PASS2)) &&
                      (r_cnt == '0);

    always_comb begin
        w_empty = '0;
        w_tok[0].active = w_inject;
        w_tok[0].done = 1'b0;
        w_tok[0].det = r_det;
    end

    // slot i hands its track to slot i-1 on flush; head is slot 0
    for (genvar g = 0; g < MaxTracks; g++) begin : g_cell
        t_track w_in;
        assign w_in = (g == MaxTracks - 1) ? w_empty : w_trk[(g + 1) % MaxTracks];
        gotv_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (1'b0),
            .i_shift     (w_shift),
            .i_tok       (w_tok[g]),
            .i_trk       (w_in),
            .i_pos_tol   (r_pos_tol),
            .i_area_tol  (r_area_tol),
            .i_first_pass(r_state == ST_PASS1),
            .o_tok       (w_tok[g+1]),
            .o_trk       (w_trk[g])
        );
    end

    gotv_vote u_vote (
        .i_trk  (w_trk[0]),
        .o_color(w_color),
        .o_shape(w_shape)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_cal <= 1'b0;
            r_pos_tol <= 10'd10;
            r_area_tol <= 16'd100;
            r_min_len <= 8'd10;
            r_dropped <= 1'b0;
            o_valid <= 1'b0;
            o_last <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CALIBRATED: r_cal <= i_cfg_data[0];
                    REG_POS_TOL:    r_pos_tol <= i_cfg_data[9:0];
                    REG_AREA_TOL:   r_area_tol <= i_cfg_data;
                    REG_MIN_LEN:    r_min_len <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    o_valid <= 1'b0;
                    o_last <= 1'b0;
                    r_cnt <= '0;
                    if (w_accept) begin
                        r_det <= '{x: i_pos_x, y: i_pos_y, z: i_depth_z,
                                   area: i_fill_area, color: i_color_code,
                                   shape: i_shape_code};
                        if (i_command == CMD_FLUSH) r_state <= ST_FLUSH;
                        else if (r_cal) r_state <= ST_PASS1;
                    end
                end
                ST_PASS1, ST_PASS2: begin
                    o_valid <= 1'b0;
                    o_last <= 1'b0;
                    if (r_cnt == TrkW'(MaxTracks)) begin
                        r_cnt <= '0;
                        if (w_tok[MaxTracks].done) r_state <= ST_IDLE;
                        else if (r_state == ST_PASS1) r_state <= ST_PASS2;
                        else begin
                            r_dropped <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_FLUSH: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_shift) begin
                        o_valid <= w_trk[0].valid && (w_trk[0].len > r_min_len);
                        o_last <= 1'b0;
                        o_kind <= KIND_REPORT;
                        o_obj_x <= w_trk[0].x;
                        o_obj_y <= w_trk[0].y;
                        o_obj_z <= w_trk[0].z;
                        o_obj_color <= w_color;
                        o_obj_shape <= w_shape;
                        o_overflow <= 1'b0;
                    end else begin
                        o_valid <= 1'b1;
                        o_last <= 1'b1;
                        o_kind <= KIND_END;
                        o_obj_x <= '0;
                        o_obj_y <= '0;
                        o_obj_z <= '0;
                        o_obj_color <= '0;
                        o_obj_shape <= '0;
                        o_overflow <= r_dropped;
                        r_dropped <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    o_valid <= 1'b0;
                    o_last <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `GOTV_ASSERT_IMP(a_last_is_end, i_clk, i_rst_n, o_last, o_valid && o_kind == KIND_END)
    `GOTV_ASSERT_IMP(a_end_idle, i_clk, i_rst_n, o_last, r_state == ST_IDLE)
    `GOTV_ASSERT_IMP(a_rep_in_flush, i_clk, i_rst_n, o_valid && !o_last, $past(w_shift))
    `GOTV_ASSERT_NEXT(a_table_empty, i_clk, i_rst_n, o_last, !w_trk[0].valid)
endmodule

// File: dv/gated_object_track_vote_core_tb.sv
// self-checking testbench of the track vote core: directed and random detections and flushes
`timescale 1ns / 1ps
module gated_object_track_vote_core_tb
    import gotv_pkg::*;
();

    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 40;

    typedef struct packed {
        logic       kind;
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] z;
        logic [2:0] color;
        logic [1:0] shape;
        logic       overflow;
        logic       last;
    } t_report;

    class track_scoreboard;
        logic        calibrated;
        logic [9:0]  pos_tol;
        logic [15:0] area_tol;
        logic [7:0]  min_len;
        logic        valid [MaxTracks];
        logic [9:0]  lx [MaxTracks];
        logic [9:0]  ly [MaxTracks];
        logic [7:0]  lz [MaxTracks];
        logic [15:0] la [MaxTracks];
        logic [7:0]  len [MaxTracks];
        logic [7:0]  cvotes [MaxTracks][NumColors];
        logic [7:0]  svotes [MaxTracks][NumShapes];
        logic        dropped;
        t_report     pending [$];
        int          mismatches;
        int          checked;
        int          reports;

        function new();
            calibrated = 1'b0;
            pos_tol = 10;
            area_tol = 100;
            min_len = 10;
            mismatches = 0;
            checked = 0;
            reports = 0;
            clear_tracks();
        endfunction

        function void clear_tracks();
            for (int t = 0; t < MaxTracks; t++) begin
                valid[t] = 1'b0;
                lx[t] = '0; ly[t] = '0; lz[t] = '0; la[t] = '0; len[t] = '0;
                for (int c = 0; c < NumColors; c++) cvotes[t][c] = '0;
                for (int s = 0; s < NumShapes; s++) svotes[t][s] = '0;
            end
            dropped = 1'b0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                REG_CALIBRATED: calibrated = data[0];
                REG_POS_TOL:    pos_tol = data[9:0];
                REG_AREA_TOL:   area_tol = data;
                REG_MIN_LEN:    min_len = data[7:0];
                default: ;
            endcase
        endfunction

        function bit near(int v, int r, int tol);
            return v > r - tol && v < r + tol;
        endfunction

        function logic [7:0] bump(logic [7:0] c);
            return (c == CntMax) ? c : c + 8'd1;
        endfunction

        function void absorb(int t, t_det d);
            lx[t] = d.x; ly[t] = d.y; lz[t] = d.z; la[t] = d.area;
            len[t] = bump(len[t]);
            if (d.color < NumColors) cvotes[t][d.color] = bump(cvotes[t][d.color]);
            if (d.shape < NumShapes) svotes[t][d.shape] = bump(svotes[t][d.shape]);
        endfunction

        function void note_transaction(logic cmd, t_det d);
            t_report r;
            int col;
            int shp;
            if (cmd == CMD_DETECT) begin
                if (!calibrated) return;
                for (int t = 0; t < MaxTracks; t++) begin
                    if (valid[t] && near(d.x, lx[t], pos_tol) && near(d.y, ly[t], pos_tol)
                            && near(d.area, la[t], area_tol)) begin
                        absorb(t, d);
                        return;
                    end
                end
                for (int t = 0; t < MaxTracks; t++) begin
                    if (!valid[t]) begin
                        valid[t] = 1'b1;
                        len[t] = '0;
                        for (int c = 0; c < NumColors; c++) cvotes[t][c] = '0;
                        for (int s = 0; s < NumShapes; s++) svotes[t][s] = '0;
                        absorb(t, d);
                        return;
                    end
                end
                dropped = 1'b1;
                return;
            end
            for (int t = 0; t < MaxTracks; t++) begin
                if (valid[t] && len[t] > min_len) begin
                    col = 0;
                    shp = 0;
                    for (int c = 1; c < NumColors; c++) if (cvotes[t][c] > cvotes[t][col]) col = c;
                    for (int s = 1; s < NumShapes; s++) if (svotes[t][s] > svotes[t][shp]) shp = s;
                    r = '{KIND_REPORT, lx[t], ly[t], lz[t], col[2:0], shp[1:0], 1'b0, 1'b0};
                    pending = {pending, r};
                end
            end
            r = '{KIND_END, 10'd0, 10'd0, 8'd0, 3'd0, 2'd0, dropped, 1'b1};
            pending = {pending, r};
            clear_tracks();
        endfunction

        function void check_report(t_report got);
            t_report exp;
            checked++;
            if (got.kind == KIND_REPORT) reports++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind || got.x !== exp.x || got.y !== exp.y || got.z !== exp.z
                    || got.color !== exp.color || got.shape !== exp.shape
                    || got.overflow !== exp.overflow || got.last !== exp.last) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_start;
    logic        o_busy;
    logic        i_command;
    logic [9:0]  i_pos_x;
    logic [9:0]  i_pos_y;
    logic [7:0]  i_depth_z;
    logic [15:0] i_fill_area;
    logic [2:0]  i_color_code;
    logic [1:0]  i_shape_code;
    logic        o_valid;
    logic        o_kind;
    logic [9:0]  o_obj_x;
    logic [9:0]  o_obj_y;
    logic [7:0]  o_obj_z;
    logic [2:0]  o_obj_color;
    logic [1:0]  o_obj_shape;
    logic        o_overflow;
    logic        o_last;

    gated_object_track_vote_core i_dut (.*);

    track_scoreboard sb = new();
    int cycles = 0;
    int sent = 0;
    int flushes = 0;
    int burst_left = 0;
    int anchor_x [4];
    int anchor_y [4];
    int anchor_a [4];

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && o_valid)
            sb.check_report('{o_kind, o_obj_x, o_obj_y, o_obj_z, o_obj_color, o_obj_shape,
                              o_overflow, o_last});
    end

    // sender bursts: a random gap after each burst, sometimes none
    task automatic pace();
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            if ($urandom_range(0, 3) != 0) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_transaction(logic cmd, int x, int y, int z, int a, int c, int s);
        t_det d;
        pace();
        d = '{x[9:0], y[9:0], z[7:0], a[15:0], c[2:0], s[1:0]};
        i_start <= 1'b1;
        i_command <= cmd;
        i_pos_x <= d.x; i_pos_y <= d.y; i_depth_z <= d.z;
        i_fill_area <= d.area; i_color_code <= d.color; i_shape_code <= d.shape;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_transaction(cmd, d);
        sent++;
        if (cmd == CMD_FLUSH) flushes++;
    endtask

    task automatic flush();
        send_transaction(CMD_FLUSH, $urandom_range(0, 1023), $urandom_range(0, 1023),
                         $urandom_range(0, 255), $urandom_range(0, 65535),
                         $urandom_range(0, 7), $urandom_range(0, 3));
    endtask

    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0 || o_busy) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        logic [15:0] data;
        data = value[15:0];
        // junk above the register width must be dropped
        if (idx == REG_CALIBRATED) data[15:1] = 15'($urandom);
        if (idx == REG_POS_TOL) data[15:10] = 6'($urandom);
        if (idx == REG_MIN_LEN) data[15:8] = 8'($urandom);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic setup(int cal, int ptol, int atol, int mlen);
        settle();
        write_reg(REG_CALIBRATED, cal);
        write_reg(REG_POS_TOL, ptol);
        write_reg(REG_AREA_TOL, atol);
        write_reg(REG_MIN_LEN, mlen);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int jitter(int base, int tol, int top);
        int v;
        v = base;
        if (tol > 1) v = base + $urandom_range(0, 2 * (tol - 1)) - (tol - 1);
        if (v < 0) v = 0;
        if (v > top) v = top;
        return v;
    endfunction

    initial begin
        int ptol;
        int atol;
        int k;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0; i_cfg_index <= '0; i_cfg_data <= '0;
        i_start <= 1'b0; i_command <= CMD_DETECT;
        i_pos_x <= '0; i_pos_y <= '0; i_depth_z <= '0; i_fill_area <= '0;
        i_color_code <= '0; i_shape_code <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // uncalibrated: detections ignored, flush still answers
        send_transaction(CMD_DETECT, 1023, 1023, 255, 65535, 4, 2);
        send_transaction(CMD_DETECT, 0, 0, 0, 0, 0, 0);
        flush();

        // zero tolerance never matches: fill the table and overflow it
        setup(1, 0, 0, 0);
        for (int i = 0; i <= MaxTracks; i++)
            send_transaction(CMD_DETECT, (i & 1) ? 1023 : i, (i & 2) ? 1023 : 0,
                             (i & 4) ? 255 : 0, (i & 1) ? 65535 : i, i % 8, i % 4);
        flush();

        // one wide-open track, length driven into saturation, color 3 vs 4 tie
        setup(1, 1023, 65535, 254);
        for (int i = 0; i < 256; i++)
            send_transaction(CMD_DETECT, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 255), $urandom_range(0, 65535),
                             (i % 2) ? 4 : 3, (i % 50 == 0) ? 3 : 2);
        flush();

        // random phases around a few objects with noise
        for (int ph = 0; ph < 5; ph++) begin
            ptol = (ph == 4) ? 1023 : $urandom_range(2, 40);
            atol = (ph == 3) ? 65535 : $urandom_range(2, 300);
            setup((ph == 1) ? 0 : 1, ptol, atol, (ph == 2) ? 255 : $urandom_range(0, 2));
            k = $urandom_range(1, 4);
            for (int a = 0; a < 4; a++) begin
                anchor_x[a] = $urandom_range(0, 1023);
                anchor_y[a] = $urandom_range(0, 1023);
                anchor_a[a] = $urandom_range(0, 65535);
            end
            for (int i = 0; i < 5; i++) begin
                int a;
                a = $urandom_range(0, k - 1);
                if ($urandom_range(0, 99) < 5)
                    flush();
                else if ($urandom_range(0, 99) < 12)
                    send_transaction(CMD_DETECT, $urandom_range(0, 1023),
                                     $urandom_range(0, 1023), $urandom_range(0, 255),
                                     $urandom_range(0, 65535), $urandom_range(0, 7),
                                     $urandom_range(0, 3));
                else
                    send_transaction(CMD_DETECT, jitter(anchor_x[a], ptol, 1023),
                                     jitter(anchor_y[a], ptol, 1023), $urandom_range(0, 255),
                                     jitter(anchor_a[a], atol, 65535),
                                     ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                                 : $urandom_range(0, 4),
                                     ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2));
            end
            flush();
        end

        settle();
        $display("sent %0d transactions including %0d flushes", sent, flushes);
        $display("checked %0d results, %0d track reports, %0d mismatches",
                 sb.checked, sb.reports, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
